### hdl/ats_pkg.sv
// Shared types, codes and helpers for the audiometric threshold sequencer.
// No dependencies.
package ats_pkg;

    localparam int MAX_TONES = 16;
    localparam int TONE_W    = $clog2(MAX_TONES);
    localparam int CNT_W     = $clog2(MAX_TONES + 1);
    localparam int STORE_D   = 2 * MAX_TONES;
    localparam int STORE_AW  = $clog2(STORE_D);
    localparam int LEVEL_W   = 12;
    localparam int DELAY_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_HEARD = 3'd1;
    localparam logic [2:0] OP_TICK  = 3'd2;
    localparam logic [2:0] OP_STOP  = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic [2:0] PH_END   = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_ASC   = 3'd2;
    localparam logic [2:0] PH_DESC  = 3'd3;
    localparam logic [2:0] PH_NEXT  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_UP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_DOWN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_DELAY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_COUNT = 3'd5;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level_min;
        logic signed [LEVEL_W-1:0] level_max;
        logic [7:0]                step_up;
        logic [7:0]                step_down;
        logic [DELAY_W-1:0]        tone_delay_ms;
        logic [4:0]                tone_count;
    } t_cfg;

    typedef struct packed {
        logic                      play_tone;
        logic [TONE_W-1:0]         tone_index;
        logic                      ear;
        logic signed [LEVEL_W-1:0] level;
        logic                      schedule_valid;
        logic [DELAY_W-1:0]        delay_ms;
        logic                      stop_sound;
        logic                      finished;
        logic signed [LEVEL_W-1:0] read_level;
        logic [2:0]                phase;
    } t_result;

    typedef struct packed {
        logic                      en;
        logic [STORE_AW-1:0]       addr;
        logic signed [LEVEL_W-1:0] data;
    } t_store_wr;

    function automatic logic signed [LEVEL_W-1:0] sat_level(input logic signed [LEVEL_W:0] v);
        logic signed [LEVEL_W-1:0] r;
        if (v[LEVEL_W] != v[LEVEL_W-1]) begin
            r = v[LEVEL_W] ? {1'b1, {(LEVEL_W-1){1'b0}}} : {1'b0, {(LEVEL_W-1){1'b1}}};
        end else begin
            r = $signed(v[LEVEL_W-1:0]);
        end
        return r;
    endfunction

endpackage

### hdl/ats_store.sv
// Threshold store: one level per ear and tone, with a valid bit per entry.
// Depends on ats_pkg.
module ats_store (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ats_pkg::t_store_wr                i_wr,
    input  logic [ats_pkg::STORE_AW-1:0]      i_rd_addr,
    output logic                              o_rd_valid,
    output logic signed [ats_pkg::LEVEL_W-1:0] o_rd_data
);
    import ats_pkg::*;

    logic signed [LEVEL_W-1:0] r_thr [STORE_D];
    logic [STORE_D-1:0]        r_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_thr[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    assign o_rd_valid = r_vld[i_rd_addr];
    assign o_rd_data  = r_thr[i_rd_addr];

endmodule

### hdl/ats_ctrl.sv
// Staircase phase machine: state registers and the per-item update and result.
// Depends on ats_pkg.
module ats_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic [2:0]                         i_op,
    input  ats_pkg::t_cfg                      i_cfg,
    input  logic                               i_rd_valid,
    input  logic signed [ats_pkg::LEVEL_W-1:0] i_rd_data,
    output ats_pkg::t_store_wr                 o_wr,
    output ats_pkg::t_result                   o_res
);
    import ats_pkg::*;

    logic [2:0]                r_phase, n_phase;
    logic [TONE_W-1:0]         r_tone, n_tone;
    logic                      r_ear, n_ear;
    logic signed [LEVEL_W-1:0] r_level, n_level;
    logic                      r_heard, n_heard;

    logic signed [LEVEL_W:0]   up_sum, dn_sum;
    logic signed [LEVEL_W-1:0] up_lvl, dn_lvl;
    logic [CNT_W-1:0]          eff_cnt;
    logic [CNT_W-1:0]          tone_nxt;
    logic                      post;
    logic                      store;
    t_result                   res;

    always_comb begin
        up_sum = $signed({r_level[LEVEL_W-1], r_level}) + $signed({5'd0, i_cfg.step_up});
        dn_sum = $signed({r_level[LEVEL_W-1], r_level}) - $signed({5'd0, i_cfg.step_down});
        up_lvl = sat_level(up_sum);
        dn_lvl = sat_level(dn_sum);
        if (i_cfg.tone_count == '0) begin
            eff_cnt = CNT_W'(1);
        end else if (i_cfg.tone_count > 5'(MAX_TONES)) begin
            eff_cnt = CNT_W'(MAX_TONES);
        end else begin
            eff_cnt = CNT_W'(i_cfg.tone_count);
        end
        tone_nxt = CNT_W'(r_tone) + CNT_W'(1);
    end

    always_comb begin
        n_phase = r_phase;
        n_tone  = r_tone;
        n_ear   = r_ear;
        n_level = r_level;
        n_heard = r_heard;
        post    = 1'b0;
        store   = 1'b0;
        res     = '0;
        unique case (i_op)
            OP_START: begin
                n_tone  = '0;
                n_ear   = 1'b0;
                n_level = i_cfg.level_min;
                n_heard = 1'b0;
                n_phase = PH_START;
                res.schedule_valid = 1'b1;
                res.delay_ms       = i_cfg.tone_delay_ms;
            end
            OP_HEARD: begin
                n_heard = 1'b1;
            end
            OP_STOP: begin
                res.stop_sound = 1'b1;
            end
            OP_READ: begin
                res.read_level = i_rd_valid ? i_rd_data : i_cfg.level_max;
            end
            OP_TICK: begin
                post = 1'b1;
                unique case (r_phase)
                    PH_START: begin
                        n_phase = PH_ASC;
                    end
                    PH_ASC: begin
                        if (r_heard) begin
                            n_phase = (r_level > i_cfg.level_min) ? PH_DESC : PH_NEXT;
                            store   = 1'b1;
                        end else begin
                            n_level = up_lvl;
                            if (up_lvl > i_cfg.level_max) begin
                                n_phase = PH_NEXT;
                            end
                        end
                    end
                    PH_DESC: begin
                        if (r_heard) begin
                            store = 1'b1;
                            if (r_level > i_cfg.level_min) begin
                                n_level = dn_lvl;
                            end else begin
                                n_phase = PH_NEXT;
                            end
                        end else begin
                            n_phase = PH_NEXT;
                        end
                    end
                    PH_NEXT: begin
                        if (tone_nxt < eff_cnt) begin
                            n_tone  = tone_nxt[TONE_W-1:0];
                            n_phase = PH_ASC;
                            n_level = i_cfg.level_min;
                        end else if (!r_ear) begin
                            n_ear   = 1'b1;
                            n_tone  = '0;
                            n_phase = PH_ASC;
                            n_level = i_cfg.level_min;
                        end else begin
                            n_phase = PH_END;
                        end
                    end
                    default: begin
                        // end phase, and any unused code
                        post           = 1'b0;
                        n_phase        = PH_END;
                        res.stop_sound = 1'b1;
                        res.finished   = 1'b1;
                    end
                endcase
                if (post) begin
                    if (n_phase == PH_ASC || n_phase == PH_DESC) begin
                        res.play_tone      = 1'b1;
                        res.tone_index     = n_tone;
                        res.ear            = n_ear;
                        res.level          = n_level;
                        res.schedule_valid = 1'b1;
                        res.delay_ms       = i_cfg.tone_delay_ms;
                        n_heard            = 1'b0;
                    end else if (n_phase == PH_NEXT || n_phase == PH_END) begin
                        res.schedule_valid = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        res.phase = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_END;
            r_tone  <= '0;
            r_ear   <= 1'b0;
            r_level <= '0;
            r_heard <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_tone  <= n_tone;
            r_ear   <= n_ear;
            r_level <= n_level;
            r_heard <= n_heard;
        end
    end

    assign o_wr.en   = i_en && store;
    assign o_wr.addr = {r_ear, r_tone};
    assign o_wr.data = r_level;
    assign o_res     = res;

endmodule

### hdl/audiometric_threshold_sequencer.sv
// Audiometric threshold sequencer top: config registers, item and result registers.
// An item is held in the stage-1 register; its result is then registered for output.
// One item per cycle unless the output holds a stalled result; then the input stalls.
// Reset (synchronous, active low) restores config defaults, phase end, clears valid bits.
// Depends on ats_pkg, ats_ctrl, ats_store.
module audiometric_threshold_sequencer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ats_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ats_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [2:0]                           i_operation,
    input  logic                                 i_read_ear,
    input  logic [ats_pkg::TONE_W-1:0]           i_read_tone,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_play_tone,
    output logic [ats_pkg::TONE_W-1:0]           o_tone_index,
    output logic                                 o_ear,
    output logic signed [ats_pkg::LEVEL_W-1:0]   o_level,
    output logic                                 o_schedule_valid,
    output logic [ats_pkg::DELAY_W-1:0]          o_delay_ms,
    output logic                                 o_stop_sound,
    output logic                                 o_finished,
    output logic signed [ats_pkg::LEVEL_W-1:0]   o_read_level,
    output logic [2:0]                           o_phase
);
    import ats_pkg::*;

    t_cfg                      r_cfg;
    logic                      r_s1_valid;
    logic [2:0]                r_s1_op;
    logic [STORE_AW-1:0]       r_s1_addr;
    logic                      r_out_valid;
    t_result                   r_out;

    logic                      adv;
    logic                      in_acc;
    t_store_wr                 wr;
    t_result                   res;
    logic                      rd_valid;
    logic signed [LEVEL_W-1:0] rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.level_min     <= 12'sd0;
            r_cfg.level_max     <= 12'sd800;
            r_cfg.step_up       <= 8'd50;
            r_cfg.step_down     <= 8'd100;
            r_cfg.tone_delay_ms <= 16'd1000;
            r_cfg.tone_count    <= 5'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LEVEL_MIN:  r_cfg.level_min     <= $signed(i_cfg_data[LEVEL_W-1:0]);
                REG_LEVEL_MAX:  r_cfg.level_max     <= $signed(i_cfg_data[LEVEL_W-1:0]);
                REG_STEP_UP:    r_cfg.step_up       <= i_cfg_data[7:0];
                REG_STEP_DOWN:  r_cfg.step_down     <= i_cfg_data[7:0];
                REG_TONE_DELAY: r_cfg.tone_delay_ms <= i_cfg_data[DELAY_W-1:0];
                REG_TONE_COUNT: r_cfg.tone_count    <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    assign adv        = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op   <= i_operation;
            r_s1_addr <= {i_read_ear, i_read_tone};
        end
    end

    ats_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (wr),
        .i_rd_addr  (r_s1_addr),
        .o_rd_valid (rd_valid),
        .o_rd_data  (rd_data)
    );

    ats_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (adv),
        .i_op       (r_s1_op),
        .i_cfg      (r_cfg),
        .i_rd_valid (rd_valid),
        .i_rd_data  (rd_data),
        .o_wr       (wr),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_play_tone      = r_out.play_tone;
    assign o_tone_index     = r_out.tone_index;
    assign o_ear            = r_out.ear;
    assign o_level          = r_out.level;
    assign o_schedule_valid = r_out.schedule_valid;
    assign o_delay_ms       = r_out.delay_ms;
    assign o_stop_sound     = r_out.stop_sound;
    assign o_finished       = r_out.finished;
    assign o_read_level     = r_out.read_level;
    assign o_phase          = r_out.phase;

    a_play_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_play_tone |-> (o_phase == PH_ASC || o_phase == PH_DESC))
        else $error("tone played outside a staircase phase");

    a_finish_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_finished |-> (o_stop_sound && o_phase == PH_END && !o_schedule_valid))
        else $error("finished without stop in end phase");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled with room downstream");

    a_store_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.en |-> (adv && r_s1_op == OP_TICK))
        else $error("threshold written outside a tick");

    a_no_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_schedule_valid |-> (o_delay_ms == '0))
        else $error("delay given without schedule");

endmodule
